// ===== rtl/xsr_pkg.sv =====
// Shared types, constants and substitution tables for the XOR/S-box rotate cipher.
// No dependencies; every other file imports this package.
package xsr_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int KEY_BYTES = 16;

    localparam int DATA_W  = 8;
    localparam int POS_W   = 12;
    localparam int IDX_W   = $clog2(MAX_LEN + 1);   // holds 0..MAX_LEN
    localparam int KIDX_W  = 4;
    localparam int KLEN_W  = 5;
    localparam int KEY_W   = 8 * KEY_BYTES;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 8'd3;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef struct packed {
        logic              direction;
        logic [KEY_W-1:0]  key;
        logic [KLEN_W-1:0] key_length;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_byte;
        logic [POS_W-1:0]  position;
        logic              last_of_run;
        logic              end_of_message;
        logic              too_long;
    } result_t;

    // Results produced by one accepted byte, packed toward first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } res_pair_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             sat;
    } pos_sat_t;

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Clamp the key length to 1..KEY_BYTES
    function automatic logic [KLEN_W-1:0] eff_key_len(input logic [KLEN_W-1:0] len);
        logic [KLEN_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = KLEN_W'(1);
        end else if (n > KLEN_W'(KEY_BYTES)) begin
            n = KLEN_W'(KEY_BYTES);
        end
        return n;
    endfunction

    function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                            input logic [KIDX_W-1:0] k);
        return key[8*k +: 8];
    endfunction

    // Saturate an output position at MAX_LEN-1
    function automatic pos_sat_t sat_pos(input logic [IDX_W:0] p);
        pos_sat_t r;
        if (p > (IDX_W+1)'(MAX_LEN - 1)) begin
            r.pos = POS_W'(MAX_LEN - 1);
            r.sat = 1'b1;
        end else begin
            r.pos = POS_W'(p);
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/xsr_core.sv =====
// Message state and per-byte transform: key schedule, S-box lookups, positions.
// Depends on xsr_pkg.
module xsr_core
    import xsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              last_byte,
    output res_pair_t         push
);

    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [KIDX_W-1:0] key_index_reg, key_index_next;
    logic [DATA_W-1:0] held_byte_reg, held_byte_next;
    logic              in_message_reg, in_message_next;
    logic              over_reg, over_next;
    logic              msg_dir_reg, msg_dir_next;

    logic [IDX_W-1:0]  idx;
    logic              over_cur;
    logic              dir;
    logic              first_byte;
    logic [KLEN_W-1:0] klen;
    logic [KIDX_W-1:0] k_base, k1, k2;
    logic [KLEN_W-1:0] k1_inc;
    logic [DATA_W-1:0] held_src;
    logic [7:0]        key1, key2, key_tail;
    pos_sat_t          ps_enc, ps_dec, ps_tail;
    result_t           res_main, res_tail;
    logic [1:0]        count;

    // Effective view of the state for this byte; a new message starts clean
    assign idx        = in_message_reg ? byte_index_reg : '0;
    assign over_cur   = (in_message_reg & over_reg) | (idx >= IDX_W'(MAX_LEN));
    assign dir        = in_message_reg ? msg_dir_reg : cfg.direction;
    assign first_byte = (idx == '0);

    assign klen   = eff_key_len(cfg.key_length);
    assign k_base = in_message_reg ? key_index_reg : '0;
    assign k1     = ({1'b0, k_base} < klen) ? k_base : '0;
    assign k1_inc = {1'b0, k1} + KLEN_W'(1);
    assign k2     = (k1_inc >= klen) ? '0 : k1_inc[KIDX_W-1:0];

    assign key1     = key_byte(cfg.key, k1);
    assign key2     = key_byte(cfg.key, k2);
    assign key_tail = first_byte ? key1 : key2;
    assign held_src = first_byte ? data_byte : held_byte_reg;

    assign ps_enc  = sat_pos(last_byte ? '0 : {1'b0, idx} + (IDX_W+1)'(1));
    assign ps_dec  = sat_pos({1'b0, idx} - (IDX_W+1)'(1));
    assign ps_tail = sat_pos({1'b0, idx});

    always_comb begin
        res_main = '0;
        res_tail = '0;
        count    = 2'd0;
        if (dir == DIR_ENCRYPT) begin
            res_main.result_byte    = SBOX_FWD[data_byte ^ key1];
            res_main.position       = ps_enc.pos;
            res_main.last_of_run    = 1'b1;
            res_main.end_of_message = last_byte;
            res_main.too_long       = over_cur | ps_enc.sat;
            count                   = 2'd1;
        end else begin
            res_main.result_byte    = SBOX_INV[data_byte] ^ key1;
            res_main.position       = ps_dec.pos;
            res_main.last_of_run    = ~last_byte;
            res_main.end_of_message = 1'b0;
            res_main.too_long       = over_cur | ps_dec.sat;

            res_tail.result_byte    = SBOX_INV[held_src] ^ key_tail;
            res_tail.position       = ps_tail.pos;
            res_tail.last_of_run    = 1'b1;
            res_tail.end_of_message = 1'b1;
            res_tail.too_long       = over_cur | ps_tail.sat;

            count = {1'b0, ~first_byte} + {1'b0, last_byte};
        end
    end

    always_comb begin
        push.count  = accept ? count : 2'd0;
        push.first  = (dir == DIR_DECRYPT && first_byte) ? res_tail : res_main;
        push.second = res_tail;
    end

    always_comb begin
        byte_index_next = byte_index_reg;
        key_index_next  = key_index_reg;
        held_byte_next  = held_byte_reg;
        in_message_next = in_message_reg;
        over_next       = over_reg;
        msg_dir_next    = msg_dir_reg;
        if (accept) begin
            msg_dir_next = dir;
            if (dir == DIR_DECRYPT && first_byte) begin
                held_byte_next = data_byte;
            end
            if (last_byte) begin
                in_message_next = 1'b0;
                byte_index_next = '0;
                key_index_next  = '0;
                over_next       = 1'b0;
            end else begin
                in_message_next = 1'b1;
                over_next       = over_cur;
                byte_index_next = (idx < IDX_W'(MAX_LEN)) ? idx + IDX_W'(1) : idx;
                // decrypt's first byte is only held and uses no key byte
                key_index_next  = (dir == DIR_DECRYPT && first_byte) ? k_base : k2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            key_index_reg  <= '0;
            held_byte_reg  <= '0;
            in_message_reg <= 1'b0;
            over_reg       <= 1'b0;
            msg_dir_reg    <= DIR_ENCRYPT;
        end else begin
            byte_index_reg <= byte_index_next;
            key_index_reg  <= key_index_next;
            held_byte_reg  <= held_byte_next;
            in_message_reg <= in_message_next;
            over_reg       <= over_next;
            msg_dir_reg    <= msg_dir_next;
        end
    end

endmodule

// ===== rtl/xsr_result_buf.sv =====
// Two-entry result queue; absorbs the extra result at the end of a decrypted message.
// Depends on xsr_pkg.
module xsr_result_buf
    import xsr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  res_pair_t push,
    output logic      in_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output result_t   head
);

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] rem_cnt;

    assign m_valid  = (count_reg != 2'd0);
    assign head     = slot0_reg;
    assign pop      = m_valid & m_ready;
    assign rem_cnt  = count_reg - {1'b0, pop};
    // room for two results once this cycle's transfer is out
    assign in_ready = (count_reg == 2'd0) | ((count_reg == 2'd1) & m_ready);

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = rem_cnt;
        if (rem_cnt == 2'd0) begin
            slot0_next = push.first;
            slot1_next = push.second;
            count_next = push.count;
        end else if (pop) begin
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (rem_cnt == 2'd0))
        else $error("results pushed into occupied queue");

    a_drain_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 && m_ready) |=> (count_reg == 2'd1))
        else $error("full queue did not drain by one");
`endif

endmodule

// ===== rtl/xor_sbox_rotate_cipher.sv =====
// A byte's first result, if it gives one, is registered in the queue and shows
// in the cycle after the byte is accepted. Throughput: one byte per cycle while the
// receiver keeps up; a decrypt message end gives two results and the input pauses
// while the second drains from the two-entry queue, whose room sets the rate.
// Reset (aresetn, synchronous, low): key and direction registers to defaults,
// message state cleared, result queue emptied.
module xor_sbox_rotate_cipher
    import xsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // message bytes in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_W-1:0]     s_data_byte,
    input  logic                  s_last_byte,

    // results out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_W-1:0]     m_result_byte,
    output logic [POS_W-1:0]      m_position,
    output logic                  m_last_of_run,
    output logic                  m_end_of_message,
    output logic                  m_too_long
);

    logic                  direction_reg, direction_next;
    logic [CFG_DATA_W-1:0] key_low_reg, key_low_next;
    logic [CFG_DATA_W-1:0] key_high_reg, key_high_next;
    logic [KLEN_W-1:0]     key_length_reg, key_length_next;

    cfg_t      cfg;
    logic      accept;
    res_pair_t push;
    result_t   head;

    // Config writes are always taken; unknown indexes fall through.
    assign cfg_ready = 1'b1;

    always_comb begin
        direction_next  = direction_reg;
        key_low_next    = key_low_reg;
        key_high_next   = key_high_reg;
        key_length_next = key_length_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DIRECTION: direction_next  = cfg_data[0];
                REG_KEY_LOW:   key_low_next    = cfg_data;
                REG_KEY_HIGH:  key_high_next   = cfg_data;
                REG_KEY_LEN:   key_length_next = cfg_data[KLEN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg  <= DIR_ENCRYPT;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= KLEN_W'(1);
        end else begin
            direction_reg  <= direction_next;
            key_low_reg    <= key_low_next;
            key_high_reg   <= key_high_next;
            key_length_reg <= key_length_next;
        end
    end

    // Key bytes 0..15 laid out low to high; byte k sits at bits 8k+7..8k.
    assign cfg.direction  = direction_reg;
    assign cfg.key        = {key_high_reg, key_low_reg};
    assign cfg.key_length = key_length_reg;

    // A byte transfer happens only when the queue can take both possible results.
    assign accept = s_valid & s_ready;

    xsr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .accept    (accept),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .push      (push)
    );

    xsr_result_buf u_result_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_result_byte    = head.result_byte;
    assign m_position       = head.position;
    assign m_last_of_run    = head.last_of_run;
    assign m_end_of_message = head.end_of_message;
    assign m_too_long       = head.too_long;

endmodule

// ===== tb/xsr_check_pkg.sv =====
// Scoreboard for the XOR/S-box rotate cipher: tracks message state, predicts results.
// Depends on xsr_pkg for widths, register indexes and the result_t layout.
package xsr_check_pkg;
    import xsr_pkg::*;

    localparam logic [7:0] GF_REDUCE  = 8'h1b;   // x^8 = x^4 + x^3 + x + 1
    localparam logic [7:0] SBOX_AFFINE = 8'h63;

    class cipher_sb;
        logic                  dir_reg;
        logic [CFG_DATA_W-1:0] key_lo;
        logic [CFG_DATA_W-1:0] key_hi;
        logic [KLEN_W-1:0]     key_len;

        logic [IDX_W-1:0]      byte_idx;
        logic [KIDX_W-1:0]     key_idx;
        logic [DATA_W-1:0]     held;
        logic                  in_msg;
        logic                  over;
        logic                  msg_dir;

        logic [7:0] fwd_box [256];
        logic [7:0] inv_box [256];
        result_t    due_results [$];
        int         mismatches;
        int         results_seen;

        function new();
            logic [7:0] a, b, p, q;
            int x, y, k;
            // S-box from the GF(2^8) inverse and the affine map
            for (x = 0; x < 256; x++) begin
                q = 8'h00;
                for (y = 1; y < 256; y++) begin
                    a = x[7:0];
                    b = y[7:0];
                    p = 8'h00;
                    for (k = 0; k < 8; k++) begin
                        if (b[0]) p = p ^ a;
                        a = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
                        b = b >> 1;
                    end
                    if (p == 8'h01) q = y[7:0];
                end
                p = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                      ^ {q[3:0], q[7:4]} ^ SBOX_AFFINE;
                fwd_box[x] = p;
                inv_box[p] = x[7:0];
            end
            dir_reg      = DIR_ENCRYPT;
            key_lo       = '0;
            key_hi       = '0;
            key_len      = KLEN_W'(1);
            byte_idx     = '0;
            key_idx      = '0;
            held         = '0;
            in_msg       = 1'b0;
            over         = 1'b0;
            msg_dir      = DIR_ENCRYPT;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DIRECTION: dir_reg = data[0];
                REG_KEY_LOW:   key_lo  = data;
                REG_KEY_HIGH:  key_hi  = data;
                REG_KEY_LEN:   key_len = data[KLEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Key byte for this use; a stale index past a shrunk length restarts at 0
        function logic [7:0] next_key();
            logic [KEY_W-1:0] key;
            int n, k;
            n = int'(key_len);
            if (n == 0) n = 1;
            else if (n > KEY_BYTES) n = KEY_BYTES;
            k = (int'(key_idx) < n) ? int'(key_idx) : 0;
            key_idx = (k + 1 >= n) ? '0 : KIDX_W'(k + 1);
            key = {key_hi, key_lo};
            return key[8*k +: 8];
        endfunction

        function void push(logic [7:0] val, int pos, logic run_end, logic msg_end);
            result_t r;
            r.too_long = over;
            if (pos > MAX_LEN - 1) begin
                pos = MAX_LEN - 1;
                r.too_long = 1'b1;
            end
            r.result_byte    = val;
            r.position       = POS_W'(pos);
            r.last_of_run    = run_end;
            r.end_of_message = msg_end;
            due_results.insert(due_results.size(), r);
        endfunction

        function void take_byte(logic [DATA_W-1:0] d, logic last);
            int idx;
            if (!in_msg) begin
                in_msg   = 1'b1;
                msg_dir  = dir_reg;
                byte_idx = '0;
                key_idx  = '0;
                over     = 1'b0;
            end
            idx = int'(byte_idx);
            if (idx >= MAX_LEN) over = 1'b1;
            if (msg_dir == DIR_ENCRYPT) begin
                push(fwd_box[d ^ next_key()], last ? 0 : idx + 1, 1'b1, last);
            end else begin
                if (idx == 0) held = d;
                else push(inv_box[d] ^ next_key(), idx - 1, !last, 1'b0);
                if (last) push(inv_box[held] ^ next_key(), idx, 1'b1, 1'b1);
            end
            if (last) begin
                in_msg   = 1'b0;
                byte_idx = '0;
                key_idx  = '0;
                over     = 1'b0;
            end else if (idx < MAX_LEN) begin
                byte_idx = IDX_W'(idx + 1);
            end
        endfunction

        function void check_out(result_t got);
            result_t want;
            results_seen++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result byte=%02h pos=%0d run=%0b eom=%0b tl=%0b",
                             got.result_byte, got.position, got.last_of_run,
                             got.end_of_message, got.too_long);
                return;
            end
            want = due_results.pop_front();
            if (got.result_byte !== want.result_byte || got.position !== want.position ||
                got.last_of_run !== want.last_of_run ||
                got.end_of_message !== want.end_of_message ||
                got.too_long !== want.too_long) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d expected byte=%02h pos=%0d run=%0b eom=%0b tl=%0b",
                             results_seen, want.result_byte, want.position,
                             want.last_of_run, want.end_of_message, want.too_long);
                    $display("       got                byte=%02h pos=%0d run=%0b eom=%0b tl=%0b",
                             got.result_byte, got.position, got.last_of_run,
                             got.end_of_message, got.too_long);
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for xor_sbox_rotate_cipher: drives config, byte and result channels.
// Depends on xsr_pkg (RTL types and register indexes) and xsr_check_pkg (scoreboard).
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xsr_pkg::*;
    import xsr_check_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1620;
    localparam int DRAIN_PAUSE  = 4;     // covers the registered result path with margin
    localparam int END_PAUSE    = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;   // no register lives here

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_data_byte = '0;
    logic                  s_last_byte = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [DATA_W-1:0]     m_result_byte;
    logic [POS_W-1:0]      m_position;
    logic                  m_last_of_run;
    logic                  m_end_of_message;
    logic                  m_too_long;

    cipher_sb    sb;
    result_t     seen;
    int          bytes_sent    = 0;
    int          messages_sent = 0;
    int          reg_writes    = 0;
    int          burst_left    = 0;
    int          stall_cycles  = 0;
    int          seg_left      = 0;
    logic [15:0] ready_mask    = '1;
    logic [3:0]  ready_phase   = '0;

    always #(HALF_PERIOD) aclk = ~aclk;

    xor_sbox_rotate_cipher i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_byte    (m_result_byte),
        .m_position       (m_position),
        .m_last_of_run    (m_last_of_run),
        .m_end_of_message (m_end_of_message),
        .m_too_long       (m_too_long)
    );

    // Monitor: every transfer is sampled with the values from before the edge.
    // Input bytes are noted ahead of results so a same-edge result always
    // finds its expectation queued.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                reg_writes++;
            end
            if (s_valid && s_ready) sb.take_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                seen.result_byte    = m_result_byte;
                seen.position       = m_position;
                seen.last_of_run    = m_last_of_run;
                seen.end_of_message = m_end_of_message;
                seen.too_long       = m_too_long;
                sb.check_out(seen);
            end
        end
    end

    // Receiver: a 16-bit ready mask replayed over segments of random length.
    // Masks range from always ready to sparse; bit 0 is kept set so a stall
    // never outlasts one pass over the mask.
    always @(posedge aclk) begin
        if (seg_left == 0) begin
            seg_left <= $urandom_range(20, 300);
            case ($urandom_range(0, 3))
                0: ready_mask <= '1;
                1: ready_mask <= 16'($urandom) | 16'h0001;
                2: ready_mask <= 16'($urandom & $urandom & $urandom) | 16'h0001;
                default: ready_mask <= 16'h00ff;
            endcase
        end else begin
            seg_left <= seg_left - 1;
        end
        m_ready     <= ready_mask[ready_phase];
        ready_phase <= ready_phase + 1'b1;
    end

    // Watchdog: any transfer on any channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("timeout: no transfer for %0d cycles, %0d results still due",
                 STALL_LIMIT, sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    // Leaves cfg_valid high; the next byte or settle() closes it, so back-to-back
    // writes never drop and re-raise valid in one step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // One byte transfer. The sender runs in bursts; a gap of random length
    // (possibly none) opens when a burst runs out.
    task automatic send_byte(input logic [DATA_W-1:0] d, input logic last);
        int gap;
        cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        bytes_sent++;
        if (last) messages_sent++;
    endtask

    // Idle the block: stop sending, wait out every due result, then the drain pause
    // as well, since a first decrypt byte gives no result to wait for.
    task automatic settle();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    // Random content with extra weight on 00/ff; now and then the block is
    // idled mid-message and direction or key length rewritten.
    task automatic send_message(input int len);
        logic [DATA_W-1:0] d;
        int i;
        for (i = 0; i < len; i++) begin
            if (i != 0 && $urandom_range(0, 255) == 0) begin
                settle();
                if ($urandom_range(0, 1))
                    cfg_write(REG_DIRECTION, CFG_DATA_W'($urandom_range(0, 1)));
                else
                    cfg_write(REG_KEY_LEN, CFG_DATA_W'($urandom_range(0, 31)));
            end
            d = DATA_W'($urandom);
            if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 1) ? 8'hff : 8'h00;
            send_byte(d, i == len - 1);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random register set; upper data bits carry junk the block must drop
    task automatic random_config();
        logic [CFG_DATA_W-1:0] word;
        word    = {$urandom, $urandom};
        word[0] = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) cfg_write(REG_DIRECTION, word);
        if ($urandom_range(0, 3) != 0) cfg_write(REG_KEY_LOW, pick_key());
        if ($urandom_range(0, 3) != 0) cfg_write(REG_KEY_HIGH, pick_key());
        word = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: word[KLEN_W-1:0] = '0;                       // taken as 1
            1: word[KLEN_W-1:0] = KLEN_W'(1);
            2: word[KLEN_W-1:0] = KLEN_W'(KEY_BYTES);
            3: word[KLEN_W-1:0] = KLEN_W'(KEY_BYTES + 1);   // clamped
            4: word[KLEN_W-1:0] = '1;
            default: word[KLEN_W-1:0] = KLEN_W'($urandom_range(1, KEY_BYTES));
        endcase
        if ($urandom_range(0, 3) != 0) cfg_write(REG_KEY_LEN, word);
        if ($urandom_range(0, 7) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(int'(REG_KEY_LEN) + 1,
                                                (1 << CFG_IDX_W) - 1)),
                      {$urandom, $urandom});
    endtask

    initial begin
        int i, len, start_count;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed: key bytes include 00 and ff, length 3 ---
        cfg_write(REG_KEY_LOW,   64'hff00_5aa5_0123_4567);
        cfg_write(REG_KEY_HIGH,  64'h89ab_cdef_00ff_7e81);
        cfg_write(REG_KEY_LEN,   CFG_DATA_W'(3));
        cfg_write(REG_DIRECTION, CFG_DATA_W'(DIR_ENCRYPT));
        // encrypt: extremes, then a one-byte message
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        send_byte(8'h80, 1'b1);
        // decrypt: one-byte message, then a short one (first byte held, no result)
        settle();
        cfg_write(REG_DIRECTION, CFG_DATA_W'(DIR_DECRYPT));
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b1);
        // direction flipped mid-message: current message stays decrypt
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        settle();
        cfg_write(REG_DIRECTION, CFG_DATA_W'(DIR_ENCRYPT));
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
        // key shrunk mid-message: index 6 is past the new length 4, restarts at 0
        settle();
        cfg_write(REG_KEY_LEN, CFG_DATA_W'(KEY_BYTES));
        cfg_write(REG_NONE, '1);
        for (i = 0; i < 6; i++) send_byte(8'(8'hc0 + i), 1'b0);
        settle();
        cfg_write(REG_KEY_LEN, CFG_DATA_W'(4));
        send_byte(8'h3c, 1'b0);
        send_byte(8'hc3, 1'b1);

        // --- random phases: new settings, then a handful of messages ---
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS) begin
            settle();
            random_config();
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 9))
                    0: len = 1;
                    1: len = 2;
                    9: len = $urandom_range(25, 160);
                    default: len = $urandom_range(3, 24);
                endcase
                send_message(len);
            end
        end

        settle();
        repeat (END_PAUSE) @(posedge aclk);

        $display("Sent %0d bytes in %0d messages with %0d register writes; %0d results compared",
                 bytes_sent, messages_sent, reg_writes, sb.results_seen);
        $display("Both directions, key lengths 0 to 31, messages of 1 to 160 bytes; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
